### rtl/core/oemc_pkg.sv
// Shared types, codes and fixed-point constants of the obstacle emergency mode controller.
package oemc_pkg;

  // Field widths of the input and result words.
  localparam int KIND_W   = 3;
  localparam int IR_W     = 10;
  localparam int MODE_W   = 2;
  localparam int REPORT_W = 2;
  localparam int ACK_W    = 2;
  localparam int CM_W     = 8;

  // Configuration registers.
  localparam int THR_W      = 8;
  localparam int EMT_W      = 10;
  localparam int AVG_W      = 6;
  localparam int BLK_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [THR_W-1:0] THR_RST  = 8'd30;
  localparam logic [EMT_W-1:0] EMT_RST  = 10'd500;
  localparam logic [AVG_W-1:0] AVG_RST  = 6'd50;
  localparam logic [BLK_W-1:0] BLK_RST  = 8'd250;
  localparam logic [CM_W-1:0]  MEAN_RST = 8'd30;

  // Fixed-point datapath.
  localparam int Q_FRAC     = 16;   // volts and polynomial accumulator fraction bits
  localparam int V_W        = 18;   // volts, Q2.16, at most 3.3 V
  localparam int ACC_W      = 32;   // signed Horner accumulator
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 20;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int VAL_W      = 17;   // distance sample, Q9.8
  localparam int VAL_MAX    = 131071;
  localparam int Q8_SHIFT   = 8;    // Q.16 to Q.8
  localparam int TOT_W      = 22;
  localparam int MEAN_SHIFT = 8;
  localparam int X_W        = TOT_W - MEAN_SHIFT;
  localparam int VOLT_NUM   = 33;   // 3.3 V * 10, the scale is divided by 10 * full code
  localparam int HORNER_STEPS = 4;

  localparam logic signed [ACC_W-1:0] HORNER_LEAD = ACC_W'(24 * 65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_MAIN   = 3'd0,
    KIND_BUTTON = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_TIMER  = 3'd4
  } kind_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAIT   = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_EMERG  = 2'd2
  } mode_e;

  typedef enum logic [REPORT_W-1:0] {
    REP_NONE    = 2'd0,
    REP_ENTERED = 2'd1,
    REP_LEFT    = 2'd2
  } report_e;

  typedef enum logic [ACK_W-1:0] {
    ACK_NONE     = 2'd0,
    ACK_ACCEPTED = 2'd1,
    ACK_REFUSED  = 2'd2
  } ack_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_EMERG_TICKS  = 2'd1,
    CFG_AVG_PERIOD   = 2'd2,
    CFG_BLINK_PERIOD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic              motor_on;
    report_e           emergency_report;
    ack_e              command_ack;
    logic              distance_valid;
    logic [CM_W-1:0]   distance_cm;
    logic              status_led;
    logic              side_lights;
  } result_t;

  // Polynomial coefficients in Q.16, highest remaining order first.
  function automatic logic signed [ACC_W-1:0] horner_coef(input logic [1:0] step);
    logic signed [ACC_W-1:0] c;
    unique case (step)
      2'd0:    c = ACC_W'(-160 * 65536);
      2'd1:    c = ACC_W'(406 * 65536);
      2'd2:    c = ACC_W'(-474 * 65536);
      default: c = ACC_W'(234 * 65536);
    endcase
    return c;
  endfunction

endpackage

### rtl/core/oemc_if.sv
// Handshake channels of the obstacle emergency mode controller: input words and result words.
interface oemc_in_if import oemc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IR_W-1:0]   ir_sample;

  modport source (output valid, kind, ir_sample, input ready);
  modport sink   (input valid, kind, ir_sample, output ready);
endinterface

interface oemc_out_if import oemc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic                motor_on;
  logic [REPORT_W-1:0] emergency_report;
  logic [ACK_W-1:0]    command_ack;
  logic                distance_valid;
  logic [CM_W-1:0]     distance_cm;
  logic                status_led;
  logic                side_lights;

  modport source (output valid, mode, motor_on, emergency_report, command_ack,
                  distance_valid, distance_cm, status_led, side_lights, input ready);
  modport sink   (input valid, mode, motor_on, emergency_report, command_ack,
                  distance_valid, distance_cm, status_led, side_lights, output ready);
endinterface

### rtl/core/obstacle_emergency_mode_controller.sv
// Top level of the obstacle emergency mode controller: mode logic, IR conversion and averaging.
//
// Usage: words enter on in_i (valid/ready) and every accepted word yields exactly one
// result word on out_o (valid/ready). Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; a write takes effect at that edge.
// Button, start, stop, timer and unknown words update the mode logic at acceptance and
// show their result word in the cycle after, so they can follow each other every cycle
// while the receiver does not stall. A main tick word runs the IR conversion on one shared
// signed multiplier under a small sequencer: volts scaling in states VQ, VC and VF, each
// of the four Horner steps in HM and HA, and the window update in SUM, where the result
// is loaded. When the word also closes an averaging period, the states MQ, MC and MF
// divide the window sum and the result is loaded in MF. The next word is taken once the
// sequencer is idle and the result register is free or being read. The multiplier is
// the only arithmetic unit of weight. Reset clears the mode to wait, the window and sum
// to zero, the mean to 30 cm and loads the register defaults; no clearing pass is
// needed. When the receiver stalls, the result word holds in the output register and no
// new word is taken until that word is accepted or is accepted in the same cycle.
module obstacle_emergency_mode_controller import oemc_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  oemc_in_if.sink               in_i,
  oemc_out_if.source            out_o
);

  localparam int  POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int  A_W     = SAMPLE_BITS + 6;            // code times 33
  localparam int  R_W     = A_W + Q_FRAC + 1;
  localparam longint MAXCODE = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint VDIV    = 10 * MAXCODE;
  localparam int  VSHIFT  = SAMPLE_BITS + 6;
  // Reciprocal of the volts divisor; the estimate is at most one below the exact quotient.
  localparam longint VRECIP  = (longint'(1) << (SAMPLE_BITS + 22)) / VDIV;
  localparam int  MRECIP  = (1 << X_W) / WINDOW;
  localparam logic [1:0] LAST_STEP = 2'(HORNER_STEPS - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_VQ   = 10'b0000000010,
    S_VC   = 10'b0000000100,
    S_VF   = 10'b0000001000,
    S_HM   = 10'b0000010000,
    S_HA   = 10'b0000100000,
    S_SUM  = 10'b0001000000,
    S_MQ   = 10'b0010000000,
    S_MC   = 10'b0100000000,
    S_MF   = 10'b1000000000
  } state_e;

  // Configuration registers.
  logic [THR_W-1:0] thr_q;
  logic [EMT_W-1:0] emt_q;
  logic [AVG_W-1:0] avg_per_q;
  logic [BLK_W-1:0] blk_per_q;

  // Mode and timing state.
  mode_e            mode_q, mode_d;
  logic             motor_q, motor_d;
  logic [EMT_W-1:0] hold_cnt_q, hold_cnt_d;
  logic             hold_run_q, hold_run_d;
  logic [AVG_W-1:0] avg_cnt_q, avg_cnt_d;
  logic [BLK_W-1:0] blink_cnt_q, blink_cnt_d;
  logic             led_q, led_d;
  logic             side_q, side_d;
  logic             fire_q, fire_d;
  logic [CM_W-1:0]  mean_q;
  report_e          report_c;
  ack_e             ack_c;

  // Sequencer and datapath.
  state_e                     state_q, state_d;
  logic [1:0]                 step_q;
  logic [A_W-1:0]             a_q;
  logic [V_W-1:0]             v_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [X_W-1:0]             m_q;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]    acc_sh;
  logic [VAL_W-1:0]           val_c;
  logic [R_W-1:0]             vrem;
  logic [X_W-1:0]             mean_x, mrem;
  logic [X_W:0]               mean_full;
  logic [CM_W-1:0]            mean_c;

  // Sample window.
  logic [VAL_W-1:0] ring_q [WINDOW];
  logic [POS_W-1:0] pos_q;
  logic [TOT_W-1:0] total_q;

  // Handshake and result words.
  logic              in_ready, in_fire, is_main;
  logic [IR_W+SAMPLE_BITS-1:0] ir_ext;
  logic [SAMPLE_BITS-1:0] code;
  logic [BLK_W-1:0]  blink_inc;
  logic [AVG_W-1:0]  avg_inc;
  logic [EMT_W:0]    hold_inc;
  result_t           res_d, res_q, out_d, out_q;
  logic              out_valid_q, out_valid_d;

  assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign is_main     = (in_i.kind == KIND_MAIN);

  // Only the low SAMPLE_BITS bits of the IR code take part.
  assign ir_ext = {{SAMPLE_BITS{1'b0}}, in_i.ir_sample};
  assign code   = ir_ext[SAMPLE_BITS-1:0];

  assign blink_inc = blink_cnt_q + 1'b1;
  assign avg_inc   = avg_cnt_q + 1'b1;
  assign hold_inc  = {1'b0, hold_cnt_q} + 1'b1;

  // Mode logic: all control effects of a word are settled at acceptance. The emergency
  // test of a main tick sees the mean left by the previous average.
  always_comb begin
    mode_d      = mode_q;
    motor_d     = motor_q;
    hold_cnt_d  = hold_cnt_q;
    hold_run_d  = hold_run_q;
    avg_cnt_d   = avg_cnt_q;
    blink_cnt_d = blink_cnt_q;
    led_d       = led_q;
    side_d      = side_q;
    fire_d      = fire_q;
    report_c    = REP_NONE;
    ack_c       = ACK_NONE;
    if (in_fire) begin
      unique case (in_i.kind)
        KIND_MAIN: begin
          if (blink_inc >= blk_per_q) begin
            blink_cnt_d = '0;
            led_d       = ~led_q;
            side_d      = (mode_q == MODE_EMERG) ? ~side_q : 1'b0;
          end else begin
            blink_cnt_d = blink_inc;
          end
          if (mean_q < thr_q) begin
            if (mode_q != MODE_EMERG) begin
              report_c = REP_ENTERED;
            end
            mode_d     = MODE_EMERG;
            hold_cnt_d = '0;
            hold_run_d = 1'b1;
          end
          motor_d   = (mode_d == MODE_MOVING);
          fire_d    = (avg_inc >= avg_per_q);
          avg_cnt_d = fire_d ? '0 : avg_inc;
        end
        KIND_BUTTON: begin
          if (mode_q == MODE_WAIT) begin
            mode_d = MODE_MOVING;
          end else if (mode_q == MODE_MOVING) begin
            mode_d = MODE_WAIT;
          end
        end
        KIND_START, KIND_STOP: begin
          if (mode_q != MODE_EMERG) begin
            ack_c  = ACK_ACCEPTED;
            mode_d = (in_i.kind == KIND_START) ? MODE_MOVING : MODE_WAIT;
          end else begin
            ack_c  = ACK_REFUSED;
          end
        end
        KIND_TIMER: begin
          if (hold_run_q) begin
            if (hold_inc > {1'b0, emt_q}) begin
              report_c   = REP_LEFT;
              hold_cnt_d = '0;
              hold_run_d = 1'b0;
              mode_d     = MODE_WAIT;
            end else begin
              hold_cnt_d = hold_inc[EMT_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_d.mode             = mode_d;
    res_d.motor_on         = motor_d;
    res_d.emergency_report = report_c;
    res_d.command_ack      = ack_c;
    res_d.distance_valid   = 1'b0;
    res_d.distance_cm      = '0;
    res_d.status_led       = led_d;
    res_d.side_lights      = side_d;
  end

  // Operand selection of the shared multiplier; the product is always registered.
  always_comb begin
    unique case (state_q)
      S_VQ: begin
        mul_a = MUL_A_W'(VRECIP);
        mul_b = MUL_B_W'(a_q);
      end
      S_VC: begin
        mul_a = MUL_A_W'(prod_q[VSHIFT +: V_W]);
        mul_b = MUL_B_W'(VDIV);
      end
      S_HM: begin
        mul_a = acc_q;
        mul_b = MUL_B_W'(v_q);
      end
      S_MQ: begin
        mul_a = MUL_A_W'(MRECIP);
        mul_b = MUL_B_W'(mean_x);
      end
      S_MC: begin
        mul_a = MUL_A_W'(prod_q[X_W +: X_W]);
        mul_b = MUL_B_W'(WINDOW);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = prod_q >>> Q_FRAC;

  // Remainder check of the volts quotient: the estimate may be one short.
  assign vrem = {1'b0, a_q, {Q_FRAC{1'b0}}} - prod_q[R_W-1:0];

  // Polynomial result brought to Q9.8 and clamped.
  always_comb begin
    acc_sh = acc_q >>> Q8_SHIFT;
    if (acc_sh < 0) begin
      val_c = '0;
    end else if (acc_sh > ACC_W'(VAL_MAX)) begin
      val_c = VAL_W'(VAL_MAX);
    end else begin
      val_c = acc_sh[VAL_W-1:0];
    end
  end

  // Mean of the window: whole centimetres first, then the division by WINDOW.
  assign mean_x    = total_q[TOT_W-1:MEAN_SHIFT];
  assign mrem      = mean_x - prod_q[X_W-1:0];
  assign mean_full = (X_W+1)'(m_q) + (X_W+1)'(mrem >= X_W'(WINDOW));
  assign mean_c    = (mean_full > (X_W+1)'(255)) ? {CM_W{1'b1}} : mean_full[CM_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire && is_main) state_d = S_VQ;
      S_VQ:    state_d = S_VC;
      S_VC:    state_d = S_VF;
      S_VF:    state_d = S_HM;
      S_HM:    state_d = S_HA;
      S_HA:    state_d = (step_q == LAST_STEP) ? S_SUM : S_HM;
      S_SUM:   state_d = fire_q ? S_MQ : S_IDLE;
      S_MQ:    state_d = S_MC;
      S_MC:    state_d = S_MF;
      S_MF:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The output register is empty whenever the sequencer is busy, so each load is safe.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    if (in_fire && !is_main) begin
      out_valid_d = 1'b1;
      out_d       = res_d;
    end
    if ((state_q == S_SUM) && !fire_q) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
    if (state_q == S_MF) begin
      out_valid_d          = 1'b1;
      out_d                = res_q;
      out_d.distance_valid = 1'b1;
      out_d.distance_cm    = mean_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RST;
      emt_q     <= EMT_RST;
      avg_per_q <= AVG_RST;
      blk_per_q <= BLK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:    thr_q     <= cfg_data_i[THR_W-1:0];
        CFG_EMERG_TICKS:  emt_q     <= cfg_data_i[EMT_W-1:0];
        CFG_AVG_PERIOD:   avg_per_q <= cfg_data_i[AVG_W-1:0];
        CFG_BLINK_PERIOD: blk_per_q <= cfg_data_i[BLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_WAIT;
      motor_q     <= 1'b0;
      hold_cnt_q  <= '0;
      hold_run_q  <= 1'b0;
      avg_cnt_q   <= '0;
      blink_cnt_q <= '0;
      led_q       <= 1'b0;
      side_q      <= 1'b0;
      fire_q      <= 1'b0;
      mean_q      <= MEAN_RST;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      motor_q     <= motor_d;
      hold_cnt_q  <= hold_cnt_d;
      hold_run_q  <= hold_run_d;
      avg_cnt_q   <= avg_cnt_d;
      blink_cnt_q <= blink_cnt_d;
      led_q       <= led_d;
      side_q      <= side_d;
      fire_q      <= fire_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_VF) begin
        step_q <= '0;
      end else if (state_q == S_HA) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == S_SUM) begin
        total_q       <= total_q - TOT_W'(ring_q[pos_q]) + TOT_W'(val_c);
        ring_q[pos_q] <= val_c;
        pos_q         <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
      if (state_q == S_MF) begin
        mean_q <= mean_c;
      end
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
    if (in_fire && is_main) begin
      a_q   <= (A_W'(code) << 5) + A_W'(code);
      res_q <= res_d;
    end
    if (state_q == S_VC) begin
      v_q <= prod_q[VSHIFT +: V_W];
    end
    if (state_q == S_VF) begin
      if (vrem >= R_W'(VDIV)) begin
        v_q <= v_q + 1'b1;
      end
      acc_q <= HORNER_LEAD;
    end
    if (state_q == S_HA) begin
      acc_q <= prod_sh[ACC_W-1:0] + horner_coef(step_q);
    end
    if (state_q == S_MC) begin
      m_q <= prod_q[X_W +: X_W];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.mode             = out_q.mode;
  assign out_o.motor_on         = out_q.motor_on;
  assign out_o.emergency_report = out_q.emergency_report;
  assign out_o.command_ack      = out_q.command_ack;
  assign out_o.distance_valid   = out_q.distance_valid;
  assign out_o.distance_cm      = out_q.distance_cm;
  assign out_o.status_led       = out_q.status_led;
  assign out_o.side_lights      = out_q.side_lights;

  // An accepted word either starts the sequencer or has its result loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE) || out_valid_q)
    else $error("accepted word produced neither work nor a result");

  // The result register must be empty while a main tick is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result register occupied while the sequencer is busy");

  // The emergency hold timer only runs while in emergency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_run_q |-> (mode_q == MODE_EMERG))
    else $error("hold timer running outside emergency");

  // A window update without an average period ends with a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) && !fire_q |=> out_valid_q && !out_q.distance_valid)
    else $error("main tick result missing or carries a distance");

  // No distance is reported without the valid flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.distance_valid |-> (out_q.distance_cm == '0))
    else $error("distance field set without distance_valid");

endmodule
